>>> design/tlik_pkg.sv
// Shared types, constants and functions for the two-link inverse kinematics core.
package tlik_pkg;

	localparam int CORDIC_MAX = 24;
	localparam int ANGLE_W = 32;
	localparam int VEC_W = 56;

	localparam logic signed [ANGLE_W-1:0] PI_Q29 = 32'sd1686629713;
	localparam logic signed [15:0] PI_Q13 = 16'sd25736;
	localparam logic [14:0] ONE_Q14 = 15'd16384;

	// Arctangent of 2^-i in Q2.29
	function automatic logic signed [ANGLE_W-1:0] atan_q29(input logic [4:0] i);
		logic signed [ANGLE_W-1:0] r;
		case (i)
			5'd0: r = 32'sd421657428;
			5'd1: r = 32'sd248918915;
			5'd2: r = 32'sd131521918;
			5'd3: r = 32'sd66762579;
			5'd4: r = 32'sd33510843;
			5'd5: r = 32'sd16771758;
			5'd6: r = 32'sd8387925;
			5'd7: r = 32'sd4194219;
			5'd8: r = 32'sd2097141;
			5'd9: r = 32'sd1048575;
			5'd10: r = 32'sd524288;
			5'd11: r = 32'sd262144;
			5'd12: r = 32'sd131072;
			5'd13: r = 32'sd65536;
			5'd14: r = 32'sd32768;
			5'd15: r = 32'sd16384;
			5'd16: r = 32'sd8192;
			5'd17: r = 32'sd4096;
			5'd18: r = 32'sd2048;
			5'd19: r = 32'sd1024;
			5'd20: r = 32'sd512;
			5'd21: r = 32'sd256;
			5'd22: r = 32'sd128;
			5'd23: r = 32'sd64;
			default: r = '0;
		endcase
		return r;
	endfunction

	// One vector travelling through the CORDIC row
	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [ANGLE_W-1:0] z;
	} vec_t;

	// Side data carried along with the vectors
	typedef struct packed {
		logic unr;
	} side_t;

endpackage

>>> design/tlik_cell.sv
// One CORDIC vectoring cell: a micro-rotation of two vectors at a fixed shift.
module tlik_cell import tlik_pkg::*; #(
	parameter int SHIFT = 0
) (
	input logic clk,
	input logic arst_n,
	input logic vld_in,
	input vec_t va_in,
	input vec_t vb_in,
	input side_t side_in,
	output logic vld_out,
	output vec_t va_out,
	output vec_t vb_out,
	output side_t side_out
);

	function automatic vec_t rot(input vec_t v);
		vec_t r;
		logic signed [VEC_W-1:0] xs;
		logic signed [VEC_W-1:0] ys;
		xs = v.x >>> SHIFT;
		ys = v.y >>> SHIFT;
		if (!v.y[VEC_W-1]) begin
			r.x = v.x + ys;
			r.y = v.y - xs;
			r.z = v.z + atan_q29(5'(SHIFT));
		end else begin
			r.x = v.x - ys;
			r.y = v.y + xs;
			r.z = v.z - atan_q29(5'(SHIFT));
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		va_out <= rot(va_in);
		vb_out <= rot(vb_in);
		side_out <= side_in;
	end

endmodule

>>> design/tlik_divide.sv
// Pipelined restoring divider for the cosine quotient, one quotient bit per stage.
module tlik_divide (
	input logic clk,
	input logic arst_n,
	input logic vld_in,
	input logic [31:0] num_in,
	input logic [30:0] den_in,
	input logic neg_in,
	input logic signed [15:0] x_in,
	input logic signed [15:0] y_in,
	input logic [14:0] l1_in,
	input logic [14:0] l2_in,
	output logic vld_out,
	output logic [15:0] quo_out,
	output logic unr_out,
	output logic neg_out,
	output logic signed [15:0] x_out,
	output logic signed [15:0] y_out,
	output logic [14:0] l1_out,
	output logic [14:0] l2_out
);

	// Quotient beyond 2^14 is clamped anyway, so 16 bits of quotient suffice
	localparam int QB = 16;

	logic [QB:0] vld_q;
	logic [31:0] rem_q [QB+1];
	logic [30:0] den_q [QB+1];
	logic [QB-1:0] quo_q [QB+1];
	logic [QB:0] ovf_q;
	logic [QB:0] unr_q;
	logic [QB:0] neg_q;
	logic [QB:0] zden_q;
	logic signed [15:0] x_q [QB+1];
	logic signed [15:0] y_q [QB+1];
	logic [14:0] l1_q [QB+1];
	logic [14:0] l2_q [QB+1];

	// Stage 0: form dividend = |num|*2^14 + den/2, split against den*2^16
	logic [46:0] dvd0;
	assign dvd0 = {1'b0, num_in, 14'd0} + 47'(den_in >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[QB-1:0], vld_in};
		end
	end

	always_ff @(posedge clk) begin
		// anything at or above den*2^16 saturates
		ovf_q[0] <= (dvd0[46:QB] >= den_in);
		rem_q[0] <= (dvd0[46:QB] >= den_in) ? 32'd0 : {1'b0, dvd0[46:QB]};
		quo_q[0] <= dvd0[QB-1:0];
		den_q[0] <= den_in;
		unr_q[0] <= (den_in == 31'd0) ? (num_in != 32'd0) : ({1'b0, num_in} > {2'b0, den_in});
		zden_q[0] <= den_in == 31'd0;
		neg_q[0] <= neg_in;
		x_q[0] <= x_in;
		y_q[0] <= y_in;
		l1_q[0] <= l1_in;
		l2_q[0] <= l2_in;
		for (int i = 0; i < QB; i++) begin
			logic [32:0] t;
			t = {rem_q[i], quo_q[i][QB-1]};
			if (t >= {2'b0, den_q[i]}) begin
				rem_q[i+1] <= 32'(t - {2'b0, den_q[i]});
				quo_q[i+1] <= {quo_q[i][QB-2:0], 1'b1};
			end else begin
				rem_q[i+1] <= t[31:0];
				quo_q[i+1] <= {quo_q[i][QB-2:0], 1'b0};
			end
			den_q[i+1] <= den_q[i];
			ovf_q[i+1] <= ovf_q[i];
			unr_q[i+1] <= unr_q[i];
			zden_q[i+1] <= zden_q[i];
			neg_q[i+1] <= neg_q[i];
			x_q[i+1] <= x_q[i];
			y_q[i+1] <= y_q[i];
			l1_q[i+1] <= l1_q[i];
			l2_q[i+1] <= l2_q[i];
		end
	end

	assign vld_out = vld_q[QB];
	assign quo_out = (ovf_q[QB] || zden_q[QB]) ? 16'hFFFF : quo_q[QB];
	assign unr_out = unr_q[QB];
	assign neg_out = neg_q[QB] && !zden_q[QB];
	assign x_out = x_q[QB];
	assign y_out = y_q[QB];
	assign l1_out = l1_q[QB];
	assign l2_out = l2_q[QB];

endmodule

>>> design/tlik_sqrt.sv
// Pipelined integer square root for the sine, one result bit per stage.
module tlik_sqrt (
	input logic clk,
	input logic arst_n,
	input logic vld_in,
	input logic [28:0] val_in,
	input logic signed [15:0] c_in,
	input logic unr_in,
	input logic signed [15:0] x_in,
	input logic signed [15:0] y_in,
	input logic [14:0] l1_in,
	input logic [14:0] l2_in,
	output logic vld_out,
	output logic [14:0] s_out,
	output logic signed [15:0] c_out,
	output logic unr_out,
	output logic signed [15:0] x_out,
	output logic signed [15:0] y_out,
	output logic [14:0] l1_out,
	output logic [14:0] l2_out
);

	// 29-bit radicand gives 15 root bits
	localparam int RB = 15;

	logic [RB:0] vld_q;
	logic [29:0] rad_q [RB+1];
	logic [29:0] rem_q [RB+1];
	logic [14:0] root_q [RB+1];
	logic signed [15:0] c_q [RB+1];
	logic [RB:0] unr_q;
	logic signed [15:0] x_q [RB+1];
	logic signed [15:0] y_q [RB+1];
	logic [14:0] l1_q [RB+1];
	logic [14:0] l2_q [RB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[RB-1:0], vld_in};
		end
	end

	always_ff @(posedge clk) begin
		rad_q[0] <= {1'b0, val_in};
		rem_q[0] <= '0;
		root_q[0] <= '0;
		c_q[0] <= c_in;
		unr_q[0] <= unr_in;
		x_q[0] <= x_in;
		y_q[0] <= y_in;
		l1_q[0] <= l1_in;
		l2_q[0] <= l2_in;
		for (int i = 0; i < RB; i++) begin
			logic [29:0] t;
			logic [29:0] trial;
			t = {rem_q[i][27:0], rad_q[i][29:28]};
			trial = {13'd0, root_q[i], 2'b01};
			if (t >= trial) begin
				rem_q[i+1] <= t - trial;
				root_q[i+1] <= {root_q[i][13:0], 1'b1};
			end else begin
				rem_q[i+1] <= t;
				root_q[i+1] <= {root_q[i][13:0], 1'b0};
			end
			rad_q[i+1] <= {rad_q[i][27:0], 2'b00};
			c_q[i+1] <= c_q[i];
			unr_q[i+1] <= unr_q[i];
			x_q[i+1] <= x_q[i];
			y_q[i+1] <= y_q[i];
			l1_q[i+1] <= l1_q[i];
			l2_q[i+1] <= l2_q[i];
		end
	end

	assign vld_out = vld_q[RB];
	assign s_out = root_q[RB];
	assign c_out = c_q[RB];
	assign unr_out = unr_q[RB];
	assign x_out = x_q[RB];
	assign y_out = y_q[RB];
	assign l1_out = l1_q[RB];
	assign l2_out = l2_q[RB];

endmodule

>>> design/two_link_inverse_kinematics_core.sv
// Top level of the two-link planar inverse kinematics core.
// Fully pipelined: one target is taken every cycle (busy stays low) and each
// result appears exactly once on done. The pipeline consists of the two input
// stages, the 17-stage cosine divider, the clamp stage, the 16-stage sine square
// root, four stages of products, folding and normalisation, the row of CORDIC
// cells and the output rounding register.
// The receiver cannot stall; results are not held.
module two_link_inverse_kinematics_core import tlik_pkg::*; #(
	parameter int CORDIC_STAGES = 16
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic signed [15:0] target_x,
	input logic signed [15:0] target_y,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [14:0] cfg_data,
	output logic done,
	output logic signed [15:0] shoulder_angle,
	output logic [14:0] elbow_angle,
	output logic unreachable
);

	localparam logic REG_UPPER = 1'b0;
	localparam logic REG_LOWER = 1'b1;

	logic [14:0] l1_q, l2_q;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_q <= 15'd2048;
			l2_q <= 15'd2048;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_UPPER: l1_q <= cfg_data;
				REG_LOWER: l2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: squares
	logic vld_s1;
	logic [31:0] xx_s1, yy_s1;
	logic [29:0] l11_s1, l22_s1, l12_s1;
	logic signed [15:0] x_s1, y_s1;
	logic [14:0] l1_s1, l2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		xx_s1 <= 32'(target_x * target_x);
		yy_s1 <= 32'(target_y * target_y);
		l11_s1 <= l1_q * l1_q;
		l22_s1 <= l2_q * l2_q;
		l12_s1 <= l1_q * l2_q;
		x_s1 <= target_x;
		y_s1 <= target_y;
		l1_s1 <= l1_q;
		l2_s1 <= l2_q;
	end

	// Stage 2: numerator magnitude and sign
	logic vld_s2;
	logic [31:0] an_s2;
	logic neg_s2;
	logic [30:0] den_s2;
	logic signed [15:0] x_s2, y_s2;
	logic [14:0] l1_s2, l2_s2;
	logic signed [33:0] num_c;

	assign num_c = $signed({2'b0, xx_s1}) + $signed({2'b0, yy_s1})
		- $signed({4'b0, l11_s1}) - $signed({4'b0, l22_s1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		neg_s2 <= num_c[33];
		an_s2 <= num_c[33] ? 32'(-num_c) : 32'(num_c);
		den_s2 <= {l12_s1, 1'b0};
		x_s2 <= x_s1;
		y_s2 <= y_s1;
		l1_s2 <= l1_s1;
		l2_s2 <= l2_s1;
	end

	logic dv_vld, dv_unr, dv_neg;
	logic [15:0] dv_quo;
	logic signed [15:0] dv_x, dv_y;
	logic [14:0] dv_l1, dv_l2;

	tlik_divide u_div (
		.clk(clk), .arst_n(arst_n), .vld_in(vld_s2), .num_in(an_s2), .den_in(den_s2),
		.neg_in(neg_s2), .x_in(x_s2), .y_in(y_s2), .l1_in(l1_s2), .l2_in(l2_s2),
		.vld_out(dv_vld), .quo_out(dv_quo), .unr_out(dv_unr), .neg_out(dv_neg),
		.x_out(dv_x), .y_out(dv_y), .l1_out(dv_l1), .l2_out(dv_l2)
	);

	// Stage 3: clamp cosine, form 2^28 - c^2
	logic vld_s3, unr_s3;
	logic signed [15:0] c_s3;
	logic [28:0] rad_s3;
	logic signed [15:0] x_s3, y_s3;
	logic [14:0] l1_s3, l2_s3;
	logic [14:0] cm_c;

	assign cm_c = (dv_quo > 16'(ONE_Q14)) ? ONE_Q14 : dv_quo[14:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		c_s3 <= dv_neg ? -$signed({1'b0, cm_c}) : $signed({1'b0, cm_c});
		rad_s3 <= 29'(29'd1 << 28) - 29'(cm_c * cm_c);
		unr_s3 <= dv_unr;
		x_s3 <= dv_x;
		y_s3 <= dv_y;
		l1_s3 <= dv_l1;
		l2_s3 <= dv_l2;
	end

	logic sq_vld, sq_unr;
	logic [14:0] sq_s;
	logic signed [15:0] sq_c, sq_x, sq_y;
	logic [14:0] sq_l1, sq_l2;

	tlik_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .vld_in(vld_s3), .val_in(rad_s3), .c_in(c_s3),
		.unr_in(unr_s3), .x_in(x_s3), .y_in(y_s3), .l1_in(l1_s3), .l2_in(l2_s3),
		.vld_out(sq_vld), .s_out(sq_s), .c_out(sq_c), .unr_out(sq_unr),
		.x_out(sq_x), .y_out(sq_y), .l1_out(sq_l1), .l2_out(sq_l2)
	);

	// Stage 4: k1 = l1*2^14 + l2*c, ls = l2*s
	logic vld_s4, unr_s4;
	logic signed [31:0] k1_s4, ls_s4;
	logic signed [15:0] c_s4, x_s4, y_s4;
	logic [14:0] s_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		k1_s4 <= $signed({3'b0, sq_l1, 14'd0}) + 32'($signed({1'b0, sq_l2}) * sq_c);
		ls_s4 <= $signed({2'b0, 30'(sq_l2 * sq_s)});
		c_s4 <= sq_c;
		s_s4 <= sq_s;
		x_s4 <= sq_x;
		y_s4 <= sq_y;
		unr_s4 <= sq_unr;
	end

	// Stage 5: four products
	logic vld_s5, unr_s5;
	logic signed [47:0] kx_s5, ky_s5, lx_s5, ly_s5;
	logic signed [15:0] c_s5;
	logic [14:0] s_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		kx_s5 <= 48'(k1_s4 * x_s4);
		ky_s5 <= 48'(k1_s4 * y_s4);
		lx_s5 <= 48'(ls_s4 * x_s4);
		ly_s5 <= 48'(ls_s4 * y_s4);
		c_s5 <= c_s4;
		s_s5 <= s_s4;
		unr_s5 <= unr_s4;
	end

	// Stage 6: shoulder vector, half-plane fold
	logic vld_s6, unr_s6;
	vec_t ea_s6, sa_s6;
	logic ez_s6, sz_s6;
	logic signed [49:0] vx_c, vy_c;
	logic signed [49:0] ex_c, ey_c;

	assign vx_c = 50'(kx_s5) + 50'(ly_s5);
	assign vy_c = 50'(ky_s5) - 50'(lx_s5);
	assign ex_c = 50'(c_s5);
	assign ey_c = $signed({35'd0, s_s5});

	function automatic vec_t fold(input logic signed [49:0] x, input logic signed [49:0] y);
		vec_t r;
		if (x < 0) begin
			r.x = VEC_W'(-x);
			r.y = VEC_W'(-y);
			r.z = (y >= 0) ? PI_Q29 : -PI_Q29;
		end else begin
			r.x = VEC_W'(x);
			r.y = VEC_W'(y);
			r.z = '0;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		ea_s6 <= fold(ex_c, ey_c);
		sa_s6 <= fold(vx_c, vy_c);
		ez_s6 <= (ex_c == 0) && (ey_c == 0);
		sz_s6 <= (vx_c == 0) && (vy_c == 0);
		unr_s6 <= unr_s5;
	end

	// Stage 7: normalise so the larger magnitude lies in [2^52, 2^53)
	function automatic vec_t norm(input vec_t v, input logic zero);
		vec_t r;
		logic [VEC_W-1:0] mx, my, m;
		int sh;
		mx = v.x[VEC_W-1] ? VEC_W'(-v.x) : VEC_W'(v.x);
		my = v.y[VEC_W-1] ? VEC_W'(-v.y) : VEC_W'(v.y);
		m = (mx > my) ? mx : my;
		sh = 0;
		for (int b = 0; b <= 52; b++) begin
			if (m[b]) sh = 52 - b;
		end
		r.x = zero ? '0 : v.x <<< sh;
		r.y = zero ? '0 : v.y <<< sh;
		r.z = v.z;
		return r;
	endfunction

	logic vld_s7, unr_s7, ez_s7, sz_s7;
	vec_t ea_s7, sa_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		ea_s7 <= norm(ea_s6, ez_s6);
		sa_s7 <= norm(sa_s6, sz_s6);
		ez_s7 <= ez_s6;
		sz_s7 <= sz_s6;
		unr_s7 <= unr_s6;
	end

	// Row of CORDIC cells
	logic [CORDIC_STAGES:0] cv;
	vec_t ca [CORDIC_STAGES+1];
	vec_t cb [CORDIC_STAGES+1];
	side_t cs [CORDIC_STAGES+1];
	logic [CORDIC_STAGES:0] cez, csz;

	assign cv[0] = vld_s7;
	assign ca[0] = ea_s7;
	assign cb[0] = sa_s7;
	assign cs[0].unr = unr_s7;
	assign cez[0] = ez_s7;
	assign csz[0] = sz_s7;

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_row
		tlik_cell #(.SHIFT(g)) u_cell (
			.clk(clk), .arst_n(arst_n), .vld_in(cv[g]), .va_in(ca[g]), .vb_in(cb[g]),
			.side_in(cs[g]), .vld_out(cv[g+1]), .va_out(ca[g+1]), .vb_out(cb[g+1]),
			.side_out(cs[g+1])
		);
		always_ff @(posedge clk) begin
			cez[g+1] <= cez[g];
			csz[g+1] <= csz[g];
		end
	end

	// Round Q2.29 to Q2.13 and clamp
	function automatic logic signed [15:0] to_q13(input logic signed [ANGLE_W-1:0] a,
			input logic signed [15:0] lo);
		logic signed [ANGLE_W:0] t;
		logic signed [16:0] q;
		t = $signed({a[ANGLE_W-1], a}) + 33'sd32768;
		q = t[32:16];
		if (q < 17'(lo)) q = 17'(lo);
		if (q > 17'(PI_Q13)) q = 17'(PI_Q13);
		return q[15:0];
	endfunction

	logic signed [15:0] el_c, sh_c;
	assign el_c = cez[CORDIC_STAGES] ? 16'sd0 : to_q13(ca[CORDIC_STAGES].z, 16'sd0);
	assign sh_c = csz[CORDIC_STAGES] ? 16'sd0 : to_q13(cb[CORDIC_STAGES].z, -PI_Q13);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cv[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		shoulder_angle <= sh_c;
		elbow_angle <= el_c[14:0];
		unreachable <= cs[CORDIC_STAGES].unr;
	end

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cv[CORDIC_STAGES] |=> done) else $error("result strobe lost");
	a_elbow_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> elbow_angle <= 15'(PI_Q13)) else $error("elbow out of range");
	a_div_to_sqrt: assert property (@(posedge clk) disable iff (!arst_n)
		dv_vld |=> vld_s3) else $error("cosine word dropped");

endmodule

>>> test/tb_two_link_inverse_kinematics_core.sv
// Self-checking testbench for the two-link inverse kinematics core.
`timescale 1ns / 1ps

module tb_two_link_inverse_kinematics_core;
	import tlik_pkg::*;

	localparam int STAGES = 16;
	localparam int LATENCY = STAGES + 46;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic REG_UPPER = 1'b0;
	localparam logic REG_LOWER = 1'b1;
	localparam longint ANG_PI = 64'sd1686629713;
	localparam longint ANG_PI_Q13 = 64'sd25736;
	localparam longint UNIT = 64'sd16384;

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
	} target_t;

	typedef struct {
		logic signed [15:0] shoulder;
		logic [14:0] elbow;
		logic unr;
	} joints_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [15:0] target_x = '0;
	logic signed [15:0] target_y = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = REG_UPPER;
	logic [14:0] cfg_data = '0;
	logic done;
	logic signed [15:0] shoulder_angle;
	logic [14:0] elbow_angle;
	logic unreachable;

	target_t targets[$];
	joints_t expected_joints[$];
	logic [14:0] upper_len = 15'd2048;
	logic [14:0] lower_len = 15'd2048;
	int idle_pct = 0;
	int errors = 0;
	longint cycles = 0;

	two_link_inverse_kinematics_core #(.CORDIC_STAGES(STAGES)) DUT (.*);

	always #6 clk = ~clk;

	function automatic longint sqrt_floor(input longint v);
		longint r, b;
		r = 0;
		b = 64'sd1 << 30;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else
				r = r >> 1;
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint atan_table(input int i);
		longint t[24] = '{421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
			8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072, 65536, 32768,
			16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64};
		return t[i];
	endfunction

	// Vectoring CORDIC, angle in Q2.29
	function automatic longint vector_angle(input longint y, input longint x);
		longint base, z, xs, ys, m, ax, ay;
		base = 0;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			base = (y >= 0) ? ANG_PI : -ANG_PI;
			x = -x;
			y = -y;
		end
		ax = x < 0 ? -x : x;
		ay = y < 0 ? -y : y;
		m = ax > ay ? ax : ay;
		while (m < (64'sd1 << 52)) begin
			x = x * 2;
			y = y * 2;
			m = m * 2;
		end
		for (int i = 0; i < STAGES && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + atan_table(i);
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - atan_table(i);
			end
		end
		return base + z;
	endfunction

	function automatic longint round_q13(input longint a, input longint lo, input longint hi);
		longint q;
		q = (a + 32768) >>> 16;
		if (q < lo) q = lo;
		if (q > hi) q = hi;
		return q;
	endfunction

	function automatic joints_t solve_joints(input logic signed [15:0] tx,
			input logic signed [15:0] ty);
		joints_t r;
		longint x, y, l1, l2, num, den, an, q, c, s, k1, ls;
		x = tx;
		y = ty;
		l1 = upper_len;
		l2 = lower_len;
		num = x * x + y * y - l1 * l1 - l2 * l2;
		den = 2 * l1 * l2;
		if (den == 0) begin
			c = UNIT;
			r.unr = (num != 0);
		end else begin
			an = num < 0 ? -num : num;
			q = (an * UNIT + den / 2) / den;
			r.unr = an > den;
			if (q > UNIT) q = UNIT;
			c = num < 0 ? -q : q;
		end
		s = sqrt_floor(UNIT * UNIT - c * c);
		r.elbow = 15'(round_q13(vector_angle(s, c), 0, ANG_PI_Q13));
		k1 = l1 * UNIT + l2 * c;
		ls = l2 * s;
		r.shoulder = 16'(round_q13(vector_angle(-ls * x + k1 * y, k1 * x + ls * y),
			-ANG_PI_Q13, ANG_PI_Q13));
		return r;
	endfunction

	// Driver: present queued targets, idling at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				expected_joints.push_back(solve_joints(target_x, target_y));
				void'(targets.pop_front());
			end
			if (start && busy) begin
				start <= 1'b1;
			end else if (targets.size() > 0 && $urandom_range(99) >= idle_pct) begin
				start <= 1'b1;
				target_x <= targets[0].x;
				target_y <= targets[0].y;
			end else
				start <= 1'b0;
		end
	end

	// Monitor: check results, track register writes, count cycles
	always @(posedge clk) begin
		joints_t e;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout", $time);
			$display("== FAIL ==");
			$finish;
		end
		if (arst_n && cfg_valid && cfg_ready) begin
			if (cfg_index == REG_UPPER) upper_len <= cfg_data;
			else upper_len <= upper_len;
			if (cfg_index == REG_LOWER) lower_len <= cfg_data;
		end
		if (arst_n && done) begin
			if (expected_joints.size() == 0) begin
				$display("%0t: unexpected word sh=%0d el=%0d unr=%0d", $time,
					shoulder_angle, elbow_angle, unreachable);
				errors++;
			end else begin
				e = expected_joints.pop_front();
				if (shoulder_angle !== e.shoulder) begin
					$display("%0t: shoulder_angle expected %0d actual %0d", $time,
						e.shoulder, shoulder_angle);
					errors++;
				end
				if (elbow_angle !== e.elbow) begin
					$display("%0t: elbow_angle expected %0d actual %0d", $time,
						e.elbow, elbow_angle);
					errors++;
				end
				if (unreachable !== e.unr) begin
					$display("%0t: unreachable expected %0d actual %0d", $time,
						e.unr, unreachable);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(input logic idx, input logic [14:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (targets.size() > 0 || expected_joints.size() > 0 || start)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	task automatic add_target(input int x, input int y);
		target_t t;
		t.x = 16'(x);
		t.y = 16'(y);
		targets.push_back(t);
	endtask

	// Half the points within a square just beyond the arm's reach, a quarter anywhere, a quarter near the origin
	task automatic add_random(input int n);
		int reach, r;
		for (int i = 0; i < n; i++) begin
			reach = int'(upper_len) + int'(lower_len);
			if (reach > 32767) reach = 32767;
			case ($urandom_range(3))
				0: add_target($urandom, $urandom);
				1: add_target($urandom_range(64) - 32, $urandom_range(64) - 32);
				default: begin
					r = reach + 64;
					if (r > 32767) r = 32767;
					add_target(int'($urandom_range(2 * r)) - r, int'($urandom_range(2 * r)) - r);
				end
			endcase
		end
	endtask

	initial begin
		int l1s[6] = '{2048, 32767, 1, 1, 0, 4096};
		int l2s[6] = '{2048, 32767, 1, 32767, 0, 2048};
		int pcts[6] = '{0, 71, 7, 0, 71, 7};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < 6; p++) begin
			if (p > 0) begin
				if (l1s[p] == 0) begin
					l1s[p] = $urandom_range(32767, 1);
					l2s[p] = $urandom_range(32767, 1);
				end
				write_reg(REG_UPPER, 15'(l1s[p]));
				write_reg(REG_LOWER, 15'(l2s[p]));
				@(posedge clk);
			end
			idle_pct = pcts[p];
			// field extremes, origin, each half-plane, a fully stretched and a fully folded arm
			add_target(32767, 32767);
			add_target(-32768, -32768);
			add_target(32767, -32768);
			add_target(-32768, 32767);
			add_target(0, 0);
			add_target(-32768, 0);
			add_target(0, -32768);
			add_target(-4096, 0);
			add_target(-4096, -1);
			add_target(l1s[p] + l2s[p] > 32767 ? 32767 : l1s[p] + l2s[p], 0);
			add_target(0, l1s[p] > l2s[p] ? l1s[p] - l2s[p] : l2s[p] - l1s[p]);
			add_target(1, -1);
			add_random(140);
			drain();
		end
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
